// File: design/rcfp_pkg.sv
package rcfp_pkg;

    localparam int CHANNELS      = 16;
    localparam int CHANNEL_WIDTH = 11;

    // payload bytes needed to hold all packed channels
    localparam int STORE_BYTES = (CHANNELS * CHANNEL_WIDTH + 7) / 8;
    localparam int STORE_AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 11;

    // bit accumulator: up to CHANNEL_WIDTH-1 leftover bits plus one new byte
    localparam int ACC_W = (CHANNEL_WIDTH + 7 > VALUE_W) ? CHANNEL_WIDTH + 7 : VALUE_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hC8;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hEE;
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST  = 8'h16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SYNC  = 2'd0,
        CFG_SECOND_SYNC = 2'd1,
        CFG_FRAME_TYPE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_PARSE = 4'b0001,
        ST_READ  = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

endpackage

// File: design/rc_channel_frame_parser.sv
// RC-channel frame parser.
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received byte
// per request. A frame opens on either sync byte, then carries a length byte,
// a type byte and payload. Payload bytes go into a 22-byte store memory.
// When the byte count reaches length + 2 the store is read back byte by byte
// into a bit accumulator and 16 channel values of 11 bits come out in order on
// the output channel (o_ch_valid / i_ch_ready), the final one flagged by
// o_last_channel.
// Bytes are taken one per cycle while parsing. Readout steps through a read
// and a load state for each store byte, then an emit state that sends a channel
// while at least 11 bits are held and otherwise returns to the read state for
// the next store byte. No byte is taken during readout.
// A stalled receiver holds the output register; the readout waits with it.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the two sync
// bytes and the frame type; write it only while the block is idle.
// Reset (i_rst_n low, synchronous) returns to parsing, restores the register
// defaults and marks every store byte as zero.
module rc_channel_frame_parser
    import rcfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_ch_valid,
    input  logic                 i_ch_ready,
    output logic [INDEX_W-1:0]   o_channel_index,
    output logic [VALUE_W-1:0]   o_channel_value,
    output logic                 o_last_channel
);

    localparam logic [ACC_W-1:0] CH_MASK = {ACC_W{1'b1}} >> (ACC_W - CHANNEL_WIDTH);

    logic [BYTE_W-1:0]   r_first_sync, r_second_sync, r_frame_type;
    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]   r_frame_length, n_frame_length;

    logic [BYTE_W-1:0]   r_store [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_store_vld;
    logic [BYTE_W-1:0]   r_rd_data;
    logic                r_rd_vld;
    logic [STORE_AW-1:0] r_rd_addr, n_rd_addr;

    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [INDEX_W-1:0]  r_ch, n_ch;

    logic                r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]  r_out_index, n_out_index;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic                r_out_last, n_out_last;

    logic                in_fire;
    logic [COUNT_W-1:0]  byte_idx;
    logic [COUNT_W-1:0]  count_inc;
    logic                store_we;
    logic                out_free;
    logic [ACC_W-1:0]    chan_word;
    logic [ACC_W-1:0]    load_bits;
    logic                ch_last;

    assign o_rx_ready      = (r_state == ST_PARSE);
    assign in_fire         = i_rx_valid && o_rx_ready;
    assign byte_idx        = r_byte_count - COUNT_W'(3);
    assign count_inc       = r_byte_count + COUNT_W'(1);
    assign store_we        = in_fire && (r_byte_count >= COUNT_W'(3))
                             && (byte_idx < COUNT_W'(STORE_BYTES));
    assign out_free        = !r_out_valid || i_ch_ready;
    assign chan_word       = r_acc & CH_MASK;
    // a byte never written since reset reads as zero
    assign load_bits       = {{(ACC_W-BYTE_W){1'b0}}, (r_rd_vld ? r_rd_data : '0)} << r_cnt;
    assign ch_last         = (r_ch == INDEX_W'(CHANNELS - 1));

    assign o_ch_valid      = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;

    always_comb begin
        n_state        = r_state;
        n_byte_count   = r_byte_count;
        n_frame_length = r_frame_length;
        n_rd_addr      = r_rd_addr;
        n_acc          = r_acc;
        n_cnt          = r_cnt;
        n_ch           = r_ch;
        n_out_valid    = r_out_valid && !i_ch_ready;
        n_out_index    = r_out_index;
        n_out_value    = r_out_value;
        n_out_last     = r_out_last;

        case (r_state)
            ST_PARSE: begin
                if (in_fire) begin
                    if (r_byte_count == '0) begin
                        if (i_rx_byte == r_first_sync || i_rx_byte == r_second_sync) begin
                            n_byte_count = COUNT_W'(1);
                        end
                    end else if (r_byte_count == COUNT_W'(1)) begin
                        if (i_rx_byte < BYTE_W'(2)) begin
                            n_byte_count = '0;
                        end else begin
                            n_frame_length = i_rx_byte;
                            n_byte_count   = COUNT_W'(2);
                        end
                    end else if (r_byte_count == COUNT_W'(2)) begin
                        n_byte_count = (i_rx_byte == r_frame_type) ? COUNT_W'(3) : '0;
                    end else if (count_inc == ({1'b0, r_frame_length} + COUNT_W'(2))) begin
                        // frame complete: start readout
                        n_byte_count = '0;
                        n_rd_addr    = '0;
                        n_acc        = '0;
                        n_cnt        = '0;
                        n_ch         = '0;
                        n_state      = ST_READ;
                    end else begin
                        n_byte_count = count_inc;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_acc     = r_acc | load_bits;
                n_cnt     = r_cnt + CNT_W'(BYTE_W);
                n_rd_addr = r_rd_addr + STORE_AW'(1);
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_cnt >= CNT_W'(CHANNEL_WIDTH)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_index = r_ch;
                        n_out_value = chan_word[VALUE_W-1:0];
                        n_out_last  = ch_last;
                        n_acc       = r_acc >> CHANNEL_WIDTH;
                        n_cnt       = r_cnt - CNT_W'(CHANNEL_WIDTH);
                        n_ch        = r_ch + INDEX_W'(1);
                        if (ch_last) begin
                            n_state = ST_PARSE;
                        end
                    end
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync   <= FIRST_SYNC_RST;
            r_second_sync  <= SECOND_SYNC_RST;
            r_frame_type   <= FRAME_TYPE_RST;
            r_state        <= ST_PARSE;
            r_byte_count   <= '0;
            r_frame_length <= '0;
            r_out_valid    <= 1'b0;
            r_store_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIRST_SYNC:  r_first_sync  <= i_cfg_data;
                    CFG_SECOND_SYNC: r_second_sync <= i_cfg_data;
                    CFG_FRAME_TYPE:  r_frame_type  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state        <= n_state;
            r_byte_count   <= n_byte_count;
            r_frame_length <= n_frame_length;
            r_out_valid    <= n_out_valid;
            if (store_we) begin
                r_store_vld[byte_idx[STORE_AW-1:0]] <= 1'b1;
            end
        end
        r_rd_addr   <= n_rd_addr;
        r_acc       <= n_acc;
        r_cnt       <= n_cnt;
        r_ch        <= n_ch;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[byte_idx[STORE_AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_store[r_rd_addr];
        r_rd_vld  <= r_store_vld[r_rd_addr];
    end

endmodule
